// ===== rtl/bra_pkg.sv =====
`timescale 1ns / 1ps

package bra_pkg;

	// Action codes carried in the request
	localparam logic [1:0] ACT_FIND  = 2'd0;
	localparam logic [1:0] ACT_SET   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// Request transaction payload
	typedef struct packed {
		logic [1:0]  action;
		logic [9:0]  start_req;
		logic [10:0] count;
	} bra_req_t;

	// Result transaction payload
	typedef struct packed {
		logic       ok;
		logic [9:0] position;
	} bra_rsp_t;

	// Control from the sequencer to the word unit
	typedef struct packed {
		logic is_find;
		logic set_val;
	} bra_wu_ctl_t;

	// Status from the word unit back to the sequencer
	typedef struct packed {
		logic hit;
	} bra_wu_sts_t;

endpackage

// ===== rtl/bra_ram.sv =====
`timescale 1ns / 1ps

module bra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/bra_word_unit.sv =====
`timescale 1ns / 1ps

module bra_word_unit
	import bra_pkg::*;
#(
	parameter int WORD_BITS = 32,
	parameter int PW        = 13
) (
	input  bra_wu_ctl_t                      ctl,
	input  logic [WORD_BITS-1:0]             word_in,
	input  logic signed [PW:0]               rel_lo,
	input  logic signed [PW:0]               rel_hi,
	input  logic signed [PW:0]               rel_len,
	input  logic [PW-1:0]                    want,
	input  logic [PW-1:0]                    carry_in,
	output logic [WORD_BITS-1:0]             word_out,
	output bra_wu_sts_t                      sts,
	output logic [$clog2(WORD_BITS)-1:0]     hit_off,
	output logic [PW-1:0]                    carry_out
);

	localparam int OW = $clog2(WORD_BITS);
	localparam int CW = $clog2(WORD_BITS + 1);

	// Clamp a word-relative bit bound into 0..WORD_BITS
	function automatic logic [CW-1:0] clamp_rel(input logic signed [PW:0] rel);
		logic [CW-1:0] r;
		if (rel < 0) begin
			r = '0;
		end else if (rel > $signed((PW+1)'(WORD_BITS))) begin
			r = CW'(WORD_BITS);
		end else begin
			r = rel[CW-1:0];
		end
		return r;
	endfunction

	logic [CW-1:0]        lo_c, hi_c, len_c;
	logic [WORD_BITS-1:0] sel;
	logic [WORD_BITS-1:0] used;
	logic [WORD_BITS-1:0] none_used;
	logic [OW-1:0]        last_used [WORD_BITS];
	logic [PW-1:0]        run [WORD_BITS];
	logic [WORD_BITS-1:0] hit_vec;

	assign lo_c  = clamp_rel(rel_lo);
	assign hi_c  = clamp_rel(rel_hi);
	assign len_c = clamp_rel(rel_len);

	// Range mask and occupancy view (bits past the length count as used)
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			sel[b]  = (CW'(b) >= lo_c) && (CW'(b) < hi_c);
			used[b] = word_in[b] | (CW'(b) >= len_c);
		end
	end

	// Read-modify-write merge for set and clear
	assign word_out = ctl.set_val ? (word_in | sel) : (word_in & ~sel);

	// Free run length ending at every bit, from the last used bit at or below it
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			none_used[b] = 1'b1;
			last_used[b] = '0;
			for (int j = 0; j < WORD_BITS; j++) begin
				if (j <= b && used[j]) begin
					none_used[b] = 1'b0;
					last_used[b] = OW'(j);
				end
			end
			if (none_used[b]) begin
				run[b] = carry_in + PW'(b) + PW'(1);
			end else begin
				run[b] = PW'(OW'(b) - last_used[b]);
			end
			hit_vec[b] = ctl.is_find && (run[b] == want);
		end
	end

	// Lowest bit where the run reaches the wanted length
	always_comb begin
		hit_off = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (hit_vec[b]) begin
				hit_off = OW'(b);
			end
		end
	end

	assign sts.hit   = |hit_vec;
	assign carry_out = run[WORD_BITS-1];

endmodule

// ===== rtl/bitmap_run_allocator_core.sv =====
`timescale 1ns / 1ps

// First-fit run allocator over an occupancy bitmap of NBITS bits.
// Request channel: drive req and pulse start while busy is low; the
// transaction is taken at that edge and busy rises on the next cycle.
// Result channel: done is high for exactly one cycle with rsp valid;
// the receiver cannot stall, so it must take rsp in that cycle.
// Config: cfg_we with cfg_wdata writes map_length; write only while idle.
// A find or range request scans the bitmap one word per cycle through
// a single shared word unit, fed by a RAM with registered read.
// A range request scans every word; a find that hits stops at that word,
// and a find of zero length or an unknown action answers with no scan.
// One request is in flight at a time; a new start is taken in the same
// cycle that done is shown.
// Reset clears map_length to 1024 and marks every word as never written,
// so the whole bitmap reads as free with no clearing pass.

module bitmap_run_allocator_core
	import bra_pkg::*;
#(
	parameter int NBITS     = 1024,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  bra_req_t    req,
	output logic        done,
	output bra_rsp_t    rsp,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata
);

	localparam int NWORDS = (NBITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = NWORDS > 1 ? $clog2(NWORDS) : 1;
	localparam int OW     = $clog2(WORD_BITS);
	localparam int BW     = $clog2(NBITS + WORD_BITS);
	localparam int PW     = (BW > 12 ? BW : 12) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	state_t               state_q;
	logic [10:0]          map_len_q;
	logic [AW-1:0]        cur_q;
	logic [PW-1:0]        base_q;
	logic [PW-1:0]        carry_q;
	logic [PW-1:0]        want_q;
	logic [PW-1:0]        from_q;
	logic [PW-1:0]        end_q;
	logic [PW-1:0]        len_q;
	logic [PW-1:0]        hit_end_q;
	logic                 is_find_q;
	logic                 set_val_q;
	logic                 res_ok_q;
	logic [NWORDS-1:0]    vld_q;
	logic                 rd_vld_s1;

	logic [PW-1:0]        len_w;
	logic [PW-1:0]        span_w;
	logic [PW-1:0]        end_w;
	logic [AW-1:0]        raddr;
	logic                 last_word;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] word_in;
	logic [WORD_BITS-1:0] word_out;
	logic                 ram_we;
	bra_wu_ctl_t          wu_ctl;
	bra_wu_sts_t          wu_sts;
	logic [OW-1:0]        hit_off;
	logic [PW-1:0]        carry_out;
	logic signed [PW:0]   rel_lo, rel_hi, rel_len;
	logic [PW-1:0]        pos_w;

	// Effective length and range end, worked out at accept
	always_comb begin
		len_w  = (PW'(map_len_q) > PW'(NBITS)) ? PW'(NBITS) : PW'(map_len_q);
		span_w = PW'(req.start_req) + PW'(req.count);
		end_w  = (span_w > len_w) ? len_w : span_w;
	end

	assign busy      = (state_q != ST_IDLE);
	assign last_word = (cur_q == AW'(NWORDS - 1));
	assign ram_we    = (state_q == ST_RUN) && !is_find_q;

	// Read one word ahead of the word being processed
	always_comb begin
		if (state_q == ST_RUN && !last_word) begin
			raddr = AW'(cur_q + 1'b1);
		end else if (state_q == ST_RUN) begin
			raddr = cur_q;
		end else begin
			raddr = '0;
		end
	end

	bra_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NWORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cur_q),
		.wdata(word_out),
		.raddr(raddr),
		.rdata(rdata)
	);

	// A word never written reads as all free
	assign word_in = rd_vld_s1 ? rdata : '0;

	// Word-relative bounds for the shared unit
	assign rel_lo  = $signed({1'b0, from_q}) - $signed({1'b0, base_q});
	assign rel_hi  = $signed({1'b0, end_q}) - $signed({1'b0, base_q});
	assign rel_len = $signed({1'b0, len_q}) - $signed({1'b0, base_q});

	assign wu_ctl.is_find = is_find_q;
	assign wu_ctl.set_val = set_val_q;

	bra_word_unit #(
		.WORD_BITS(WORD_BITS),
		.PW       (PW)
	) u_word_unit (
		.ctl      (wu_ctl),
		.word_in  (word_in),
		.rel_lo   (rel_lo),
		.rel_hi   (rel_hi),
		.rel_len  (rel_len),
		.want     (want_q),
		.carry_in (carry_q),
		.word_out (word_out),
		.sts      (wu_sts),
		.hit_off  (hit_off),
		.carry_out(carry_out)
	);

	// Start of the found run from its last bit
	assign pos_w = hit_end_q + PW'(1) - want_q;

	// Register-written valid flag travels with the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= vld_q[raddr];
			if (ram_we) begin
				vld_q[cur_q] <= 1'b1;
			end
		end
	end

	// Length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_len_q <= 11'd1024;
		end else if (cfg_we) begin
			map_len_q <= cfg_wdata;
		end
	end

	// Sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done      <= 1'b0;
			rsp       <= '0;
			cur_q     <= '0;
			base_q    <= '0;
			carry_q   <= '0;
			want_q    <= '0;
			from_q    <= '0;
			end_q     <= '0;
			len_q     <= '0;
			hit_end_q <= '0;
			is_find_q <= 1'b0;
			set_val_q <= 1'b0;
			res_ok_q  <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cur_q     <= '0;
						base_q    <= '0;
						carry_q   <= '0;
						want_q    <= PW'(req.count);
						from_q    <= PW'(req.start_req);
						end_q     <= end_w;
						len_q     <= len_w;
						is_find_q <= (req.action == ACT_FIND);
						set_val_q <= (req.action == ACT_SET);
						if (req.action == ACT_FIND) begin
							res_ok_q <= 1'b0;
							state_q  <= (req.count == '0) ? ST_FIN : ST_RUN;
						end else if (req.action == ACT_SET || req.action == ACT_CLEAR) begin
							res_ok_q <= (req.count == '0) || (span_w <= len_w);
							state_q  <= ST_RUN;
						end else begin
							res_ok_q <= 1'b0;
							state_q  <= ST_FIN;
						end
					end
				end
				ST_RUN: begin
					cur_q   <= AW'(cur_q + 1'b1);
					base_q  <= base_q + PW'(WORD_BITS);
					carry_q <= carry_out;
					if (is_find_q && wu_sts.hit) begin
						res_ok_q  <= 1'b1;
						hit_end_q <= base_q + PW'(hit_off);
						state_q   <= ST_FIN;
					end else if (last_word) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done         <= 1'b1;
					rsp.ok       <= res_ok_q;
					rsp.position <= (res_ok_q && is_find_q) ? pos_w[9:0] : 10'd0;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
